@@ hdl/sbr_pkg.sv @@
`timescale 1ns / 1ps
package sbr_pkg;

	localparam int unsigned IDX_W           = 48;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned CAP_W           = 7;
	localparam int unsigned PEND_OUT_W      = 7;
	localparam int unsigned S_TDATA_W       = 104;
	localparam int unsigned M_TDATA_W       = 16;
	localparam int unsigned STORE_DEPTH_DEF = 64;
	localparam int unsigned RUN_LIMIT       = 64;
	localparam int unsigned CMD_DEPTH       = 2;
	localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;

	// input kind as carried on s_tuser
	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_MARK = 1'b1;

	typedef enum logic [1:0] {
		CMD_DROP,
		CMD_DATA,
		CMD_MARK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [BYTE_W-1:0]  data;
		logic               ends;
	} sbr_cmd_t;

	typedef struct packed {
		logic     valid;
		sbr_cmd_t cmd;
	} sbr_head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOK,
		BK_EMIT
	} back_state_t;

endpackage

@@ hdl/stream_byte_reassembler.sv @@
`timescale 1ns / 1ps
// stream byte reassembler: puts out-of-order stream bytes back in order
// s_* carries one byte with its absolute index, or an end marker (s_tuser = 1),
// together with the reader's consumed count; s_tlast flags the stream's last byte
// m_* returns delivered bytes (m_tuser = 1) or one status transaction with no byte;
// m_tlast marks the final transaction caused by an input transaction
// cfg_* writes the window capacity; the block must be idle when it is written
// an input transaction is classified against the window and queued (two entries);
// the back end applies it in its idle state, then in its look state either writes
// a status transaction to the output register or starts the registered read of
// the byte store, whose byte is put out in the emit state; the next byte is not
// read until the emit state has put out the one before it
// at most 64 bytes leave per input transaction; the rest follows later inputs
// reset empties the store, clears the end record and sets the capacity to 64;
// no clearing pass is needed
// when m_tready is low the finished transaction holds in the output register
// and the back end waits; the queue keeps taking input until it fills
module stream_byte_reassembler #(
	parameter int unsigned STORE_DEPTH = sbr_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbr_pkg::CAP_W-1:0]      cfg_data,   // window_capacity
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// stream_index [47:0], data_byte [55:48], consumed_count [103:56]
	input  logic [sbr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                     s_tuser,    // func
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_data [7:0], stream_closed [8], pending_bytes [15:9]
	output logic [sbr_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                     m_tuser,    // byte_valid
	output logic                           m_tlast
);
	import sbr_pkg::*;

	logic      push;
	sbr_cmd_t  push_cmd;
	logic      push_ready;
	sbr_head_t head;
	logic      pop;

	sbr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser[0]),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	sbr_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	sbr_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser[0]),
		.m_tlast  (m_tlast)
	);

	// a status transaction carries no byte and always ends the run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
		else $error("status transaction with data or without run end");

	// closing discards everything held and only happens on a run end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tlast && (m_tdata[15:9] == 7'd0))
		else $error("closed transaction with pending bytes or mid-run");

	// once a closed transaction is taken, every later one reports closed too
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[8] ##1 m_tvalid |-> m_tdata[8] && !m_tuser[0])
		else $error("stream reopened after close");

endmodule

@@ hdl/sbr_ram.sv @@
`timescale 1ns / 1ps
module sbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/sbr_cmd_fifo.sv @@
`timescale 1ns / 1ps
module sbr_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbr_pkg::sbr_cmd_t push_cmd,
	output logic              push_ready,
	output sbr_pkg::sbr_head_t head,
	input  logic              pop
);
	import sbr_pkg::*;

	localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

	sbr_cmd_t           entry_q [CMD_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(CMD_DEPTH));
	assign do_push    = push && push_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/sbr_front.sv @@
`timescale 1ns / 1ps
module sbr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbr_pkg::CAP_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sbr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	output logic                           push,
	output sbr_pkg::sbr_cmd_t              push_cmd,
	input  logic                           push_ready
);
	import sbr_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  consumed;
	logic [IDX_W:0]    idx_ext;
	logic [IDX_W:0]    win_end;

	assign cfg_ready = 1'b1;
	assign s_tready  = push_ready;
	assign push      = s_tvalid && push_ready;

	assign idx      = s_tdata[IDX_W-1:0];
	assign consumed = s_tdata[S_TDATA_W-1 -: IDX_W];
	assign idx_ext  = {1'b0, idx};
	assign win_end  = {1'b0, consumed} + (IDX_W + 1)'(cap_q);

	// window test is stateless, the rest is left to the back end
	always_comb begin
		push_cmd.idx  = idx;
		push_cmd.data = s_tdata[IDX_W +: BYTE_W];
		push_cmd.ends = s_tlast;
		unique case (s_tuser)
			FUNC_MARK: push_cmd.kind = (idx_ext <= win_end) ? CMD_MARK : CMD_DROP;
			default:   push_cmd.kind = (idx_ext < win_end) ? CMD_DATA : CMD_DROP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

endmodule

@@ hdl/sbr_back.sv @@
`timescale 1ns / 1ps
module sbr_back #(
	parameter int unsigned STORE_DEPTH = sbr_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbr_pkg::sbr_head_t             head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbr_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import sbr_pkg::*;

	localparam int unsigned AW  = $clog2(STORE_DEPTH);
	localparam int unsigned PW  = $clog2(STORE_DEPTH + 1);
	localparam int unsigned PXW = PW + PEND_OUT_W;
	localparam int unsigned RW  = $clog2(RUN_LIMIT + 1);
	localparam logic [AW:0]      DEPTH_W    = (AW + 1)'(STORE_DEPTH);
	localparam logic [AW-1:0]    SLOT_LAST  = AW'(STORE_DEPTH - 1);
	localparam logic [IDX_W-1:0] DIFF_LIMIT = IDX_W'(STORE_DEPTH);

	back_state_t            state_q;
	back_state_t            state_nx;

	logic [IDX_W-1:0]       ne_q;
	logic [AW-1:0]          ne_slot_q;
	logic                   end_known_q;
	logic [IDX_W:0]         end_pos_q;
	logic                   closed_q;
	logic [PW-1:0]          pending_q;
	logic [STORE_DEPTH-1:0] slot_valid_q;
	logic [RW-1:0]          run_cnt_q;
	logic                   is_last_q;

	logic                   m_valid_q;
	logic                   m_byte_q;
	logic [BYTE_W-1:0]      m_data_q;
	logic                   m_last_q;
	logic                   m_closed_q;
	logic [PEND_OUT_W-1:0]  m_pend_q;

	// control from the output decode
	logic                   do_apply;
	logic                   do_take;
	logic                   do_status;
	logic                   do_byte;

	logic                   out_free;
	logic [IDX_W:0]         idx_ext;
	logic [IDX_W:0]         idx_p1;
	logic                   below;
	logic [IDX_W-1:0]       diff;
	logic                   near;
	logic                   past_end;
	logic [AW:0]            slot_sum;
	logic [AW-1:0]          wr_slot;
	logic                   store_ok;
	logic                   end_req;
	logic [IDX_W:0]         end_req_pos;

	logic                   at_end;
	logic                   can_emit;
	logic [IDX_W-1:0]       ne_nx;
	logic [AW-1:0]          ne_slot_nx;
	logic                   look_last;
	logic [PXW-1:0]         pend_wide;
	logic [PEND_OUT_W-1:0]  pend_now;
	logic [BYTE_W-1:0]      rd_data;

	assign out_free = !m_valid_q || m_tready;

	// placement of an incoming byte relative to the next expected index
	assign idx_ext  = {1'b0, head.cmd.idx};
	assign idx_p1   = idx_ext + 1'b1;
	assign below    = head.cmd.idx < ne_q;
	assign diff     = head.cmd.idx - ne_q;
	assign near     = diff < DIFF_LIMIT;
	assign past_end = end_known_q && (idx_ext >= end_pos_q);
	assign slot_sum = {1'b0, ne_slot_q} + {1'b0, diff[AW-1:0]};
	assign wr_slot  = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : slot_sum[AW-1:0];
	assign store_ok = (head.cmd.kind == CMD_DATA) && !below && near && !past_end;

	always_comb begin
		end_req     = 1'b0;
		end_req_pos = idx_p1;
		unique case (head.cmd.kind)
			CMD_MARK: begin
				end_req     = 1'b1;
				end_req_pos = idx_ext;
			end
			CMD_DATA: begin
				end_req = head.cmd.ends && (below || store_ok);
			end
			default: begin
				end_req = 1'b0;
			end
		endcase
	end

	// drain side
	assign at_end     = end_known_q && ({1'b0, ne_q} >= end_pos_q);
	assign can_emit   = !at_end && slot_valid_q[ne_slot_q];
	assign ne_nx      = ne_q + 1'b1;
	// the slot of index zero is zero, so the index wrap restarts the ring
	assign ne_slot_nx = (ne_q == '1 || ne_slot_q == SLOT_LAST) ? '0 : ne_slot_q + 1'b1;
	assign look_last  = (run_cnt_q == RW'(RUN_LIMIT - 1)) || !slot_valid_q[ne_slot_nx]
		|| (end_known_q && ({1'b0, ne_nx} >= end_pos_q));
	assign pend_wide  = PXW'(pending_q);
	assign pend_now   = pend_wide[PEND_OUT_W-1:0];

	sbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (do_apply && store_ok),
		.wr_addr (wr_slot),
		.wr_data (head.cmd.data),
		.rd_en   (do_take),
		.rd_addr (ne_slot_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (head.valid) state_nx = BK_LOOK;
			BK_LOOK: begin
				if (can_emit) begin
					state_nx = BK_EMIT;
				end else if (out_free) begin
					state_nx = BK_IDLE;
				end
			end
			BK_EMIT: if (out_free) state_nx = is_last_q ? BK_IDLE : BK_LOOK;
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		do_apply  = 1'b0;
		do_take   = 1'b0;
		do_status = 1'b0;
		do_byte   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop      = head.valid;
				do_apply = head.valid && !closed_q;
			end
			BK_LOOK: begin
				do_take   = can_emit;
				do_status = !can_emit && out_free;
			end
			BK_EMIT: begin
				do_byte = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			ne_q         <= '0;
			ne_slot_q    <= '0;
			end_known_q  <= 1'b0;
			end_pos_q    <= '0;
			closed_q     <= 1'b0;
			pending_q    <= '0;
			slot_valid_q <= '0;
			run_cnt_q    <= '0;
			is_last_q    <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (do_status || do_byte) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (pop) begin
				run_cnt_q <= '0;
			end
			if (do_apply) begin
				if (store_ok && !slot_valid_q[wr_slot]) begin
					slot_valid_q[wr_slot] <= 1'b1;
					pending_q             <= pending_q + 1'b1;
				end
				if (end_req && !end_known_q) begin
					end_known_q <= 1'b1;
					end_pos_q   <= end_req_pos;
				end
			end
			if (do_take) begin
				slot_valid_q[ne_slot_q] <= 1'b0;
				pending_q               <= pending_q - 1'b1;
				ne_q                    <= ne_nx;
				ne_slot_q               <= ne_slot_nx;
				run_cnt_q               <= run_cnt_q + 1'b1;
				is_last_q               <= look_last;
			end
			if (at_end && (do_status || (do_byte && is_last_q))) begin
				closed_q  <= 1'b1;
				pending_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_status) begin
			m_byte_q   <= 1'b0;
			m_data_q   <= '0;
			m_last_q   <= 1'b1;
			m_closed_q <= at_end;
			m_pend_q   <= at_end ? '0 : pend_now;
		end else if (do_byte) begin
			m_byte_q   <= 1'b1;
			m_data_q   <= rd_data;
			m_last_q   <= is_last_q;
			m_closed_q <= is_last_q && at_end;
			m_pend_q   <= (is_last_q && at_end) ? '0 : pend_now;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_byte_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {m_pend_q, m_closed_q, m_data_q};

endmodule
